// ----- design/sorted_priority_queue_assert.svh -----
// Assertion macros for the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEFAULT = 32;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_READ_OK  = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [15:0] prio;
		logic        [31:0] tag;
	} spq_entry_t;

	// Broadcast to every cell.
	typedef struct packed {
		logic       insert;
		spq_entry_t entry;
	} spq_ctl_t;

	// Handed from each cell to its right-hand neighbour.
	typedef struct packed {
		logic       ge;
		spq_entry_t entry;
	} spq_link_t;

endpackage

`default_nettype wire

// ----- design/spq_cell.sv -----
// One compare-and-shift cell of the sorted priority queue.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic      clk,
	input  wire spq_ctl_t  ctl,
	input  wire logic      occupied,
	input  wire spq_link_t left,
	output spq_link_t      right
);

	spq_entry_t entry_q;
	logic       ge;

	// Occupied and at least as high as the new entry: stay put.
	assign ge = occupied && ($signed(entry_q.prio) >= $signed(ctl.entry.prio));

	always_ff @(posedge clk) begin
		if (ctl.insert && !ge) begin
			entry_q <= left.ge ? ctl.entry : left.entry;
		end
	end

	assign right.ge    = ge;
	assign right.entry = entry_q;

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: cell row, count and result register.
`default_nettype none

// Sorted priority queue. Holds up to DEPTH entries (tag and signed priority)
// in descending order of priority in a row of compare-and-shift cells. An
// insert lands after every entry of equal or higher priority, so equal
// priorities keep their arrival order; a full table refuses it. A read returns
// the entry at the given position, or an out-of-range status. Every accepted
// item yields exactly one result, registered in the cycle after the transfer.
// Throughput is one item per cycle: every cell compares against the new entry
// and takes either it or its left neighbour's entry in the same cycle, and the
// position read is a single select over the row. in_ready drops only while a
// result waits in the output register and out_ready is low. No clearing pass
// is needed after reset; only the count and the output valid flag are cleared.
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic        [31:0] item_tag,
	input  wire logic signed [15:0] priority_req,
	input  wire logic        [4:0]  position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic             [1:0]  status,
	output logic             [31:0] out_tag,
	output logic signed      [15:0] out_priority,
	output logic             [5:0]  entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = CW + 5;

	logic          in_xfer;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          full;
	spq_ctl_t      ctl;
	spq_link_t     link [DEPTH+1];
	logic          occ  [DEPTH];
	spq_entry_t    rd_entry;
	logic [PW-1:0] pos_ext;
	logic          in_range;
	status_t       res_status;
	spq_entry_t    res_entry;
	logic [PW-1:0] count_ext;

	status_t       status_q;
	logic [31:0]   tag_q;
	logic [15:0]   prio_q;
	logic [5:0]    count_out_q;
	logic          out_valid_q;

	// Accept whenever the result register is free or being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign full = (count_q == CW'(DEPTH));

	assign ctl.insert     = in_xfer && (kind == KIND_INSERT) && !full;
	assign ctl.entry.prio = priority_req;
	assign ctl.entry.tag  = item_tag;

	// Left end of the row: the new entry goes in front of everything lower.
	assign link[0].ge    = 1'b1;
	assign link[0].entry = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = (count_q > CW'(i));

		spq_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occupied (occ[i]),
			.left     (link[i]),
			.right    (link[i+1])
		);
	end

	// Read select over the row; only positions below the count are used.
	assign pos_ext  = {{CW{1'b0}}, position};
	assign in_range = (pos_ext < {5'd0, count_q}) && (pos_ext < PW'(DEPTH));

	always_comb begin
		rd_entry = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (pos_ext[IW-1:0] == IW'(j)) begin
				rd_entry = link[j+1].entry;
			end
		end
	end

	// Result of the item in flight; zero payload unless a read hits.
	always_comb begin
		count_nxt = count_q;
		res_entry = '0;
		res_status = ST_INSERTED;
		case (kind)
			KIND_INSERT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_INSERTED;
					count_nxt  = count_q + CW'(1);
				end
			end
			KIND_READ: begin
				if (in_range) begin
					res_status = ST_READ_OK;
					res_entry  = rd_entry;
				end else begin
					res_status = ST_RANGE;
				end
			end
			default: begin
				res_status = ST_RANGE;
			end
		endcase
	end

	assign count_ext = {5'd0, count_nxt};

	// Hold the count and the output handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: load on every input transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q    <= res_status;
			tag_q       <= res_entry.tag;
			prio_q      <= res_entry.prio;
			count_out_q <= count_ext[5:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_tag      = tag_q;
	assign out_priority = prio_q;
	assign entry_count  = count_out_q;

endmodule

`default_nettype wire

// ----- design/spq_checker.sv -----
// Port-level checker of the sorted priority queue and its bind.
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic        [1:0]  status,
	input wire logic        [31:0] out_tag,
	input wire logic signed [15:0] out_priority,
	input wire logic        [5:0]  entry_count
);

	localparam int  CW   = $clog2(DEPTH + 1);
	localparam logic [CW+5:0] DEPTH_EXT = (CW + 6)'(DEPTH);
	localparam logic [5:0] FULL_COUNT = DEPTH_EXT[5:0];

	`SPQ_ASSERT_NEXT(a_result_follows, clk, arst_n, in_valid && in_ready, out_valid,
		"accepted item left no result")

	`SPQ_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(out_tag) && $stable(entry_count),
		"stalled result changed")

	`SPQ_ASSERT_IMPL(a_full_count, clk, arst_n, out_valid && (status == ST_FULL),
		entry_count == FULL_COUNT, "refused insert with table not full")

	`SPQ_ASSERT_IMPL(a_zero_payload, clk, arst_n, out_valid && (status != ST_READ_OK),
		(out_tag == 32'd0) && (out_priority == 16'sd0), "payload not zero on non-read")

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

`default_nettype wire
